// ===== hw/rtl/bmpl_pkg.sv =====
// Shared types and constants for the binomial-mod-prime (Lucas) block.
// Holds the controller/datapath command and status structs; no dependencies.
`timescale 1ns / 1ps

package bmpl_pkg;

  localparam int DATA_W = 63;
  localparam int OUT_W  = 16;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL_INIT,
    OP_MM_START,
    OP_FAC_WR,
    OP_POW_INIT,
    OP_ACC_WB,
    OP_POW_BIT,
    OP_INV_INIT,
    OP_INV_WR,
    OP_LOAD,
    OP_DIV_START,
    OP_READ1,
    OP_READ2,
    OP_READ3,
    OP_M_WB,
    OP_RESULT
  } dp_op_t;

  // Operand pairs for the modular multiplier.
  typedef enum logic [2:0] {
    SEL_FILL,
    SEL_SQR,
    SEL_POWB,
    SEL_T12,
    SEL_T3,
    SEL_ACC
  } mm_sel_t;

  typedef struct packed {
    dp_op_t  op;
    mm_sel_t sel;
    logic    zero_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic mm_busy;
    logic div_busy;
    logic idx_last;
    logic idx_one;
    logic exp_bit;
    logic bit_zero;
    logic r_zero;
    logic acc_zero;
    logic nd_lt_rd;
  } dp_status_t;

endpackage

// ===== hw/rtl/bmpl_in_if.sv =====
// Input channel: valid/ready handshake carrying n_total and r_chosen.
// Depends on bmpl_pkg for the field width.
`timescale 1ns / 1ps

interface bmpl_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmpl_pkg::DATA_W-1:0] n_total;
  logic [bmpl_pkg::DATA_W-1:0] r_chosen;

  modport source (output valid, output n_total, output r_chosen, input ready);
  modport sink (input valid, input n_total, input r_chosen, output ready);
endinterface

// Output channel: valid/ready handshake carrying ncr_mod.
interface bmpl_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmpl_pkg::OUT_W-1:0] ncr_mod;

  modport source (output valid, output ncr_mod, input ready);
  modport sink (input valid, input ncr_mod, output ready);
endinterface

// ===== hw/rtl/bmpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bmpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bmpl_modmul.sv =====
// Modular multiply and divide step by PRIME, using Barrett reduction: estimate, subtract, correct.
// Operands must already be below PRIME. No dependencies.
`timescale 1ns / 1ps

// With mul high the unit reduces x = a * b; with mul low it divides x = {a, b}, which
// gives one base-PRIME long-division step when a is the running remainder. In both cases
// x is below PRIME * 2^W, so quo fits in W bits. busy rises after start and falls at the
// edge that loads quo and res.
module bmpl_modmul #(
  parameter int PRIME = 65521
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mul,
  input  logic [$clog2(PRIME)-1:0]  a,
  input  logic [$clog2(PRIME)-1:0]  b,
  output logic                      busy,
  output logic [$clog2(PRIME)-1:0]  quo,
  output logic [$clog2(PRIME)-1:0]  res
);

  localparam int W = $clog2(PRIME);
  localparam logic [W:0]       MU  = (W + 1)'((64'd1 << (2 * W)) / 64'(PRIME));
  localparam logic [2*W-1:0]   P_X = (2 * W)'(PRIME);
  localparam logic [W+1:0]     P1  = (W + 2)'(PRIME);
  localparam logic [W+1:0]     P2  = (W + 2)'(2 * PRIME);

  logic [1:0]     phase;
  logic [2*W-1:0] x;
  logic [2*W-1:0] xr;
  logic [2*W+1:0] qprod;
  logic [W-1:0]   qe;
  logic [2*W-1:0] diff;
  logic [W+1:0]   r0;

  // The quotient estimate is at most two below the true quotient, so the remainder
  // before correction is below 3 * PRIME.
  always_comb begin
    x     = mul ? ((2 * W)'(a) * (2 * W)'(b)) : {a, b};
    qprod = (2 * W + 2)'(xr[2*W-1:W-1]) * (2 * W + 2)'(MU);
    diff  = xr - (2 * W)'(qe) * P_X;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 2'd0;
    end else if (busy) begin
      phase <= phase + 2'd1;
      if (phase == 2'd2) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
    end else if (busy) begin
      case (phase)
        2'd0: qe <= qprod[2*W:W+1];
        2'd1: r0 <= diff[W+1:0];
        2'd2: begin
          if (r0 >= P2) begin
            res <= W'(r0 - P2);
            quo <= qe + W'(2);
          end else if (r0 >= P1) begin
            res <= W'(r0 - P1);
            quo <= qe + W'(1);
          end else begin
            res <= W'(r0);
            quo <= qe;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bmpl_datapath.sv =====
// Datapath: table RAMs, modular multiplier, base-PRIME digit divider and registers.
// Depends on bmpl_pkg, bmpl_ram and bmpl_modmul.
`timescale 1ns / 1ps

module bmpl_datapath #(
  parameter int PRIME = 65521
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bmpl_pkg::dp_cmd_t                 cmd,
  output bmpl_pkg::dp_status_t              status,
  input  logic [bmpl_pkg::DATA_W-1:0]       n_total,
  input  logic [bmpl_pkg::DATA_W-1:0]       r_chosen,
  output logic [bmpl_pkg::OUT_W-1:0]        ncr_mod
);
  import bmpl_pkg::*;

  localparam int W   = $clog2(PRIME);
  localparam int BW  = $clog2(W);
  localparam int NCH = (DATA_W + W - 1) / W;
  localparam int QW  = NCH * W;
  localparam int DW  = $clog2(NCH + 1);
  localparam logic [W-1:0] PM1  = W'(PRIME - 1);
  localparam logic [W-1:0] EXPO = W'(PRIME - 2);

  logic [W-1:0] fval;
  logic [W-1:0] idx;
  logic [W-1:0] acc;
  logic [W-1:0] m;
  logic [W-1:0] t1;
  logic [W-1:0] t2;
  logic [W-1:0] t3;
  logic [BW-1:0] bitcnt;

  logic [QW-1:0]     nq;
  logic [QW-1:0]     rq;
  logic [W-1:0]      nrem;
  logic [W-1:0]      rrem;
  logic [DW-1:0]     dcnt;
  logic              div_busy;
  logic              div_issue;
  logic              div_step;

  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic         mm_start;
  logic [W-1:0] mm_in_a;
  logic [W-1:0] mm_in_b;
  logic         mm_busy;
  logic [W-1:0] mm_res;
  logic [W-1:0] nquo;
  logic         rdiv_busy;
  logic [W-1:0] rquo;
  logic [W-1:0] rres;

  logic         fac_we;
  logic [W-1:0] fac_waddr;
  logic [W-1:0] fac_wdata;
  logic         fac_re;
  logic [W-1:0] fac_rdata;
  logic         inv_we;
  logic [W-1:0] inv_waddr;
  logic [W-1:0] inv_wdata;
  logic         inv_re;
  logic [W-1:0] inv_raddr;
  logic [W-1:0] inv_rdata;

  always_comb begin
    case (cmd.sel)
      SEL_FILL: begin mm_a = fval; mm_b = idx;  end
      SEL_SQR:  begin mm_a = acc;  mm_b = acc;  end
      SEL_POWB: begin mm_a = acc;  mm_b = fval; end
      SEL_T12:  begin mm_a = t1;   mm_b = t2;   end
      SEL_T3:   begin mm_a = m;    mm_b = t3;   end
      SEL_ACC:  begin mm_a = acc;  mm_b = m;    end
      default:  begin mm_a = '0;   mm_b = '0;   end
    endcase
  end

  // The multiplier unit also divides n during the digit split; the two uses never overlap.
  always_comb begin
    mm_start = (cmd.op == OP_MM_START) || div_issue;
    mm_in_a  = div_issue ? nrem : mm_a;
    mm_in_b  = div_issue ? nq[QW-1 -: W] : mm_b;
    div_step = div_busy && !div_issue && !mm_busy && !rdiv_busy;
  end

  bmpl_modmul #(.PRIME(PRIME)) u_mm (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .mul   (cmd.op == OP_MM_START),
    .a     (mm_in_a),
    .b     (mm_in_b),
    .busy  (mm_busy),
    .quo   (nquo),
    .res   (mm_res)
  );

  bmpl_modmul #(.PRIME(PRIME)) u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_issue),
    .mul   (1'b0),
    .a     (rrem),
    .b     (rq[QW-1 -: W]),
    .busy  (rdiv_busy),
    .quo   (rquo),
    .res   (rres)
  );

  always_comb begin
    fac_we    = (cmd.op == OP_FILL_INIT) || (cmd.op == OP_FAC_WR);
    fac_waddr = (cmd.op == OP_FILL_INIT) ? '0 : idx;
    fac_wdata = (cmd.op == OP_FILL_INIT) ? W'(1) : mm_res;
    fac_re    = (cmd.op == OP_READ1);
    inv_we    = (cmd.op == OP_INV_INIT) || (cmd.op == OP_INV_WR);
    inv_waddr = (cmd.op == OP_INV_INIT) ? PM1 : idx - W'(1);
    inv_wdata = (cmd.op == OP_INV_INIT) ? acc : mm_res;
    inv_re    = (cmd.op == OP_READ1) || (cmd.op == OP_READ2);
    inv_raddr = (cmd.op == OP_READ1) ? rrem : nrem - rrem;
  end

  bmpl_ram #(.WIDTH(W), .DEPTH(PRIME)) u_fac_ram (
    .clk   (clk),
    .we    (fac_we),
    .waddr (fac_waddr),
    .wdata (fac_wdata),
    .re    (fac_re),
    .raddr (nrem),
    .rdata (fac_rdata)
  );

  bmpl_ram #(.WIDTH(W), .DEPTH(PRIME)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (inv_wdata),
    .re    (inv_re),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

  // Long division of n and r by PRIME in parallel, one W-bit chunk at a time from the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      div_issue <= 1'b0;
    end else if (cmd.op == OP_DIV_START) begin
      div_busy  <= 1'b1;
      div_issue <= 1'b1;
    end else if (div_issue) begin
      div_issue <= 1'b0;
    end else if (div_step) begin
      div_busy  <= (dcnt != DW'(1));
      div_issue <= (dcnt != DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FILL_INIT: begin
        fval <= W'(1);
        idx  <= W'(1);
      end
      OP_FAC_WR: begin
        fval <= mm_res;
        idx  <= idx + W'(1);
      end
      OP_POW_INIT: begin
        acc    <= W'(1);
        bitcnt <= BW'(W - 1);
      end
      OP_ACC_WB: acc <= mm_res;
      OP_POW_BIT: bitcnt <= bitcnt - BW'(1);
      OP_INV_INIT: begin
        fval <= acc;
        idx  <= PM1;
      end
      OP_INV_WR: begin
        fval <= mm_res;
        idx  <= idx - W'(1);
      end
      OP_LOAD: begin
        nq  <= QW'(n_total);
        rq  <= QW'(r_chosen);
        acc <= W'(1);
      end
      OP_DIV_START: begin
        nrem <= '0;
        rrem <= '0;
        dcnt <= DW'(NCH);
      end
      OP_READ1: begin
        if (cmd.zero_acc) begin
          acc <= '0;
        end
      end
      OP_READ2: begin
        t1 <= fac_rdata;
        t2 <= inv_rdata;
      end
      OP_READ3: t3 <= inv_rdata;
      OP_M_WB: m <= mm_res;
      OP_RESULT: ncr_mod <= OUT_W'(acc);
      default: ;
    endcase
    if (div_step) begin
      nrem <= mm_res;
      rrem <= rres;
      nq   <= {nq[QW-W-1:0], nquo};
      rq   <= {rq[QW-W-1:0], rquo};
      dcnt <= dcnt - DW'(1);
    end
  end

  always_comb begin
    status.mm_busy  = mm_busy;
    status.div_busy = div_busy;
    status.idx_last = (idx == PM1);
    status.idx_one  = (idx == W'(1));
    status.exp_bit  = EXPO[bitcnt];
    status.bit_zero = (bitcnt == '0);
    status.r_zero   = (rq == '0);
    status.acc_zero = (acc == '0);
    status.nd_lt_rd = (nrem < rrem);
  end

endmodule

// ===== hw/rtl/bmpl_ctrl.sv =====
// Controller state machine: start-up table fill, then per-item Lucas digit loop.
// Depends on bmpl_pkg; drives bmpl_datapath through command and status structs.
`timescale 1ns / 1ps

module bmpl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bmpl_pkg::dp_cmd_t    cmd,
  input  bmpl_pkg::dp_status_t status
);
  import bmpl_pkg::*;

  typedef enum logic [4:0] {
    S_FILL_INIT, S_FAC_MUL, S_FAC_WAIT,
    S_POW_INIT, S_POW_SQR, S_POW_SQR_WAIT, S_POW_MUL, S_POW_MUL_WAIT, S_POW_NEXT,
    S_INV_INIT, S_INV_MUL, S_INV_WAIT,
    S_IDLE, S_CHECK, S_DIV_WAIT, S_READ1, S_READ2, S_READ3,
    S_M12, S_M12_WAIT, S_M3, S_M3_WAIT, S_MACC, S_MACC_WAIT, S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_load;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.sel      = SEL_FILL;
    cmd.zero_acc = 1'b0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_FILL_INIT: begin
        cmd.op     = OP_FILL_INIT;
        state_next = S_FAC_MUL;
      end
      S_FAC_MUL: begin
        cmd.op     = OP_MM_START;
        state_next = S_FAC_WAIT;
      end
      S_FAC_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_FAC_WR;
          state_next = status.idx_last ? S_POW_INIT : S_FAC_MUL;
        end
      end
      S_POW_INIT: begin
        cmd.op     = OP_POW_INIT;
        state_next = S_POW_SQR;
      end
      S_POW_SQR: begin
        cmd.op     = OP_MM_START;
        cmd.sel    = SEL_SQR;
        state_next = S_POW_SQR_WAIT;
      end
      S_POW_SQR_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_ACC_WB;
          state_next = status.exp_bit ? S_POW_MUL : S_POW_NEXT;
        end
      end
      S_POW_MUL: begin
        cmd.op     = OP_MM_START;
        cmd.sel    = SEL_POWB;
        state_next = S_POW_MUL_WAIT;
      end
      S_POW_MUL_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_ACC_WB;
          state_next = S_POW_NEXT;
        end
      end
      S_POW_NEXT: begin
        if (status.bit_zero) begin
          state_next = S_INV_INIT;
        end else begin
          cmd.op     = OP_POW_BIT;
          state_next = S_POW_SQR;
        end
      end
      S_INV_INIT: begin
        cmd.op     = OP_INV_INIT;
        state_next = S_INV_MUL;
      end
      S_INV_MUL: begin
        cmd.op     = OP_MM_START;
        state_next = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_INV_WR;
          state_next = status.idx_one ? S_IDLE : S_INV_MUL;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.r_zero || status.acc_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_DIV_START;
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_READ1;
        end
      end
      S_READ1: begin
        cmd.op       = OP_READ1;
        cmd.zero_acc = status.nd_lt_rd;
        state_next   = status.nd_lt_rd ? S_CHECK : S_READ2;
      end
      S_READ2: begin
        cmd.op     = OP_READ2;
        state_next = S_READ3;
      end
      S_READ3: begin
        cmd.op     = OP_READ3;
        state_next = S_M12;
      end
      S_M12: begin
        cmd.op     = OP_MM_START;
        cmd.sel    = SEL_T12;
        state_next = S_M12_WAIT;
      end
      S_M12_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_M_WB;
          state_next = S_M3;
        end
      end
      S_M3: begin
        cmd.op     = OP_MM_START;
        cmd.sel    = SEL_T3;
        state_next = S_M3_WAIT;
      end
      S_M3_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_M_WB;
          state_next = S_MACC;
        end
      end
      S_MACC: begin
        cmd.op     = OP_MM_START;
        cmd.sel    = SEL_ACC;
        state_next = S_MACC_WAIT;
      end
      S_MACC_WAIT: begin
        if (!status.mm_busy) begin
          cmd.op     = OP_ACC_WB;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_RESULT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_FILL_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/binomial_mod_prime_lucas_top.sv =====
// Top level of the binomial-coefficient-mod-prime block (Lucas' theorem).
// Depends on bmpl_pkg, the channel interfaces, bmpl_ctrl and bmpl_datapath.
`timescale 1ns / 1ps

// Each input transfer carries n_total and r_chosen; the block returns one output
// transfer with ncr_mod = C(n_total, r_chosen) mod PRIME. After reset a start-up
// fill builds the factorial and inverse-factorial tables in two RAMs of PRIME
// entries; in_ch.ready stays low until it ends. Every modular multiplication is
// started and then goes through Barrett reduction. The fill does one multiplication
// per factorial and per inverse entry plus a square-and-multiply exponentiation over
// the W = clog2(PRIME) bits of PRIME - 2.
// Items are handled one at a time. For every base-PRIME digit position, until the
// rest of r is zero, an item takes the digit division over the NCH = ceil(63 / W)
// W-bit chunks, three table reads and three multiplications. A digit whose n digit
// is below its r digit skips the multiplications and ends the item. For the default
// PRIME there are at most four digits; the chunked division and the shared
// multiplier set the cost of each digit.
// A finished result waits in an output register, so the next item is taken while it
// is still pending; a second result waits until the first one is taken.
// ncr_mod is the residue truncated to 16 bits, exact while PRIME is at most 65536.
// PRIME must be prime.
module binomial_mod_prime_lucas_top #(
  parameter int PRIME = 65521
) (
  input logic     clk,
  input logic     rst,
  bmpl_in_if.sink   in_ch,
  bmpl_out_if.source out_ch
);
  import bmpl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences the fill and the per-digit work.
  bmpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the tables, the multiplier, the divider and the result register.
  bmpl_datapath #(.PRIME(PRIME)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .n_total  (in_ch.n_total),
    .r_chosen (in_ch.r_chosen),
    .ncr_mod  (out_ch.ncr_mod)
  );

endmodule

// ===== hw/rtl/bmpl_checker.sv =====
// Port-level checks for binomial_mod_prime_lucas_top, attached by a bind.
// Depends on bmpl_pkg for field widths.
`timescale 1ns / 1ps

module bmpl_checker #(
  parameter int PRIME = 65521
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bmpl_pkg::OUT_W-1:0]  ncr_mod
);

  // Reset starts the table fill: nothing accepted and no result shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or valid high right after reset");

  // One item at a time: no second transfer right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A result never appears in the cycle right after its item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A pending result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ncr_mod))
    else $error("pending result changed or dropped");

  // A residue stays below the modulus.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (PRIME > 65536) || (32'(ncr_mod) < PRIME))
    else $error("ncr_mod not below PRIME");

endmodule

bind binomial_mod_prime_lucas_top bmpl_checker #(.PRIME(PRIME)) u_bmpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .ncr_mod   (out_ch.ncr_mod)
);

// ===== test/bmpl_ncr_checker.sv =====
// Checker for the binomial-mod-prime block: watches both channels, predicts
// C(n, r) mod PRIME by Lucas' theorem and compares. Needs bmpl_pkg and the channel interfaces.
`timescale 1ns / 1ps

module bmpl_ncr_checker #(
  parameter int PRIME = 65521
) (
  input  logic clk,
  input  logic rst,
  bmpl_in_if   in_ch,
  bmpl_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);
  import bmpl_pkg::*;

  int unsigned fact[PRIME];
  int unsigned inv_fact[PRIME];
  logic [OUT_W-1:0] ncr_queue[$];

  function automatic longint unsigned mul_p(longint unsigned x, longint unsigned y);
    return ((x % PRIME) * (y % PRIME)) % PRIME;
  endfunction

  // Factorials upward, the last inverse by Fermat, the other inverses downward.
  initial begin
    longint unsigned base, ex, acc;
    fact[0] = 1;
    for (int i = 1; i < PRIME; i++) fact[i] = 32'(mul_p(fact[i-1], i));
    acc = 1;
    base = fact[PRIME-1];
    ex = PRIME - 2;
    while (ex > 0) begin
      if (ex[0]) acc = mul_p(acc, base);
      base = mul_p(base, base);
      ex >>= 1;
    end
    inv_fact[PRIME-1] = 32'(acc);
    for (int i = PRIME - 1; i > 0; i--) inv_fact[i-1] = 32'(mul_p(inv_fact[i], i));
  end

  function automatic logic [OUT_W-1:0] lucas_ncr(logic [DATA_W-1:0] n, logic [DATA_W-1:0] r);
    longint unsigned nn, rr, acc, nd, rd;
    nn = 64'(n);
    rr = 64'(r);
    acc = 1;
    while (rr != 0 && acc != 0) begin
      nd = nn % PRIME;
      rd = rr % PRIME;
      if (nd < rd) acc = 0;
      else acc = mul_p(acc, mul_p(mul_p(fact[nd], inv_fact[rd]), inv_fact[nd-rd]));
      nn /= PRIME;
      rr /= PRIME;
    end
    return acc[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] exp_ncr;
    if (rst) begin
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) ncr_queue.push_back(lucas_ncr(in_ch.n_total, in_ch.r_chosen));
      if (out_ch.valid && out_ch.ready) begin
        if (ncr_queue.size() == 0) begin
          $error("ncr_mod: unexpected result %0d", out_ch.ncr_mod);
          mismatches <= mismatches + 1;
        end else begin
          exp_ncr = ncr_queue.pop_front();
          if (out_ch.ncr_mod !== exp_ncr) begin
            $error("ncr_mod: expected %0d, got %0d", exp_ncr, out_ch.ncr_mod);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= ncr_queue.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the binomial-mod-prime testbench: clock, reset, stimulus and verdict.
// Needs bmpl_pkg, the channel interfaces, the block and bmpl_ncr_checker.
`timescale 1ns / 1ps

module testbench;
  import bmpl_pkg::*;

  localparam int PRIME = 65521;
  // The start-up fill dominates the run; the items add much less.
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  logic clk = 0;
  logic rst = 1;
  int mismatches;
  int outstanding;
  longint cycles = 0;

  // Idle control: gaps on both sides until the quiet tail, plus one long sink hold.
  bit quiet = 0;
  bit hold_sink = 0;

  bmpl_in_if  in_ch();
  bmpl_out_if out_ch();

  binomial_mod_prime_lucas_top #(.PRIME(PRIME)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  bmpl_ncr_checker #(.PRIME(PRIME)) ncr_check (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side. Random stall bursts, and once a long hold counted here so that
  // the block's output register fills and the input side backs up.
  initial begin
    out_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 0;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One transfer: valid stays high until accepted and is only lowered by a gap.
  task automatic send_pair(logic [DATA_W-1:0] n, logic [DATA_W-1:0] r);
    in_ch.valid    <= 1;
    in_ch.n_total  <= n;
    in_ch.r_chosen <= r;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] rand63();
    return DATA_W'({$urandom, $urandom});
  endfunction

  // Random operands: mostly one or two base-PRIME digits with r within n, some
  // full-width values, and some with r larger than n.
  task automatic send_random();
    logic [DATA_W-1:0] n, r;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(0, PRIME - 1);
        r = $urandom_range(0, n);
      end
      3, 4, 5: begin
        n = $urandom_range(0, PRIME * PRIME - 1);
        r = $urandom_range(0, n);
      end
      6: begin
        n = rand63();
        r = rand63();
      end
      7: begin
        n = rand63();
        r = n & rand63();
      end
      8: begin
        n = rand63() >> $urandom_range(0, 62);
        r = n >> $urandom_range(0, 62);
      end
      default: begin
        n = rand63() >> $urandom_range(1, 62);
        r = n + 1 + $urandom_range(0, 1000);
      end
    endcase
    send_pair(n, r);
  endtask

  initial begin
    in_ch.valid    = 0;
    in_ch.n_total  = '0;
    in_ch.r_chosen = '0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: zero cases, r above n, extremes, digit-wise zero terms.
    send_pair(0, 0);
    send_pair(ALL_ONES, 0);
    send_pair(0, 1);
    send_pair(5, 7);
    send_pair(ALL_ONES, ALL_ONES);
    send_pair(ALL_ONES - 1, ALL_ONES);
    send_pair(ALL_ONES, 1);
    send_pair(PRIME - 1, PRIME - 1);
    send_pair(PRIME - 1, (PRIME - 1) / 2);
    send_pair(PRIME, 1);
    send_pair(PRIME, PRIME);
    send_pair(PRIME + 1, 2);
    send_pair(10, 3);
    send_pair(DATA_W'(longint'(PRIME) * longint'(PRIME) - 1), PRIME * 3 + 7);
    send_pair(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_pair(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
    send_pair(ALL_ONES, 63'd1 << 62);
    send_pair(1, 1);

    repeat (250) send_random();

    // Long sink hold while items keep coming, then drain completely.
    hold_sink = 1;
    repeat (20) send_random();
    in_ch.valid <= 0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);

    repeat (80) send_random();

    quiet = 1;
    repeat (80) send_random();
    in_ch.valid <= 0;
    @(posedge clk);

    wait (outstanding == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
